// File: sv/proximity_presence_table_defines.svh
// Assertion macros for the presence table.
// Each macro expands to one labelled concurrent assertion on clk and rst_n.
`ifndef PROXIMITY_PRESENCE_TABLE_DEFINES_SVH
`define PROXIMITY_PRESENCE_TABLE_DEFINES_SVH

// Same-cycle implication
`define PPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ppt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppt_pkg;

    // Default parameter values
    localparam int unsigned MAX_DEVICES_DEF     = 16;
    localparam int unsigned COUNTER_INIT_DEF    = 65535;
    localparam int unsigned DEFAULT_TIMEOUT_DEF = 20;

    // Field widths
    localparam int unsigned ADDR_W     = 48;
    localparam int unsigned RSSI_W     = 8;
    localparam int unsigned TICK_W     = 16;
    localparam int unsigned MODE_W     = 3;
    localparam int unsigned PRES_W     = 2;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned OUT_DATA_W = 24;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_SCAN   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SETTO  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

    // Presence codes reported on a tick
    localparam logic [PRES_W-1:0] PRES_NOT_TRACKING = 2'd0;
    localparam logic [PRES_W-1:0] PRES_NONE_NEAR    = 2'd1;
    localparam logic [PRES_W-1:0] PRES_SOME_NEAR    = 2'd2;

    // One table entry as held in the memory
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [RSSI_W-1:0] thr;
        logic [TICK_W-1:0] cnt;
    } entry_t;

endpackage

`default_nettype wire

// File: sv/proximity_presence_table.sv
`timescale 1ns / 1ps
`default_nettype none
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+------------------------------------------
//  s_       | in        | s_tvalid / s_tready | tuser: mode; tdata: address, rssi, timeout
//  m_       | out       | m_tvalid / m_tready | tdata: accepted, presence, count, timeout
//
//  An item is taken in idle, then the walk reads one table entry per cycle through
//  the single memory read port, with the read data registered, and the result is
//  loaded last. Clear, unused modes and items on an empty table skip the walk.
//  Reset clears the entry count and loads the default timeout; the table memory
//  is not cleared, as entries at or above the count are never read.
//  A new item is taken in idle even while the last result waits in the output
//  register; a result finished while that register is still full waits for it.

`include "proximity_presence_table_defines.svh"

module proximity_presence_table
    import ppt_pkg::*;
#(
    parameter int unsigned MAX_DEVICES     = MAX_DEVICES_DEF,
    parameter int unsigned COUNTER_INIT    = COUNTER_INIT_DEF,
    parameter int unsigned DEFAULT_TIMEOUT = DEFAULT_TIMEOUT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [47:0] address, [55:48] rssi, [71:56] timeout_value
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [2:0] mode
    input  wire logic [MODE_W-1:0]     s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] accepted, [2:1] presence, [7:3] entry_count, [23:8] timeout_now
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    localparam int unsigned CNT_W = $clog2(MAX_DEVICES + 1);
    localparam int unsigned IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [TICK_W-1:0] CNT_INIT = TICK_W'(COUNTER_INIT);

    // Control state
    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [TICK_W-1:0] timeout_reg, timeout_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              rd_vld_reg, rd_vld_next;

    // Item and walk payload
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [RSSI_W-1:0] rssi_reg, rssi_next;
    logic [TICK_W-1:0] tval_reg, tval_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              found_reg, found_next;
    logic              near_reg, near_next;
    logic              acc_reg, acc_next;
    logic [PRES_W-1:0] pres_reg, pres_next;

    // Output register
    logic              out_acc_reg, out_acc_next;
    logic [PRES_W-1:0] out_pres_reg, out_pres_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic [TICK_W-1:0] out_timeout_reg, out_timeout_next;

    // Table memory
    entry_t            entry_mem [MAX_DEVICES];
    entry_t            rd_data_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    entry_t            mem_wd;
    logic [IDX_W-1:0]  mem_ra;
    logic              rd_issue;

    logic              accept;
    logic              last;
    logic              match;
    logic [CNT_W-1:0]  hole_idx;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_timeout_reg, out_count_reg, out_pres_reg, out_acc_reg};

    assign last     = (rd_idx_reg == used_reg - 1'b1);
    assign match    = (rd_data_reg.addr == addr_reg);
    assign hole_idx = rd_idx_reg - 1'b1;

    // Sequence the walk over the table
    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        timeout_next     = timeout_reg;
        m_tvalid_next    = m_tvalid_reg;
        rd_vld_next      = 1'b0;
        mode_next        = mode_reg;
        addr_next        = addr_reg;
        rssi_next        = rssi_reg;
        tval_next        = tval_reg;
        ptr_next         = ptr_reg;
        rd_idx_next      = rd_idx_reg;
        found_next       = found_reg;
        near_next        = near_reg;
        acc_next         = acc_reg;
        pres_next        = pres_reg;
        out_acc_next     = out_acc_reg;
        out_pres_next    = out_pres_reg;
        out_count_next   = out_count_reg;
        out_timeout_next = out_timeout_reg;
        mem_we           = 1'b0;
        mem_wa           = rd_idx_reg[IDX_W-1:0];
        mem_wd           = rd_data_reg;
        mem_ra           = ptr_reg[IDX_W-1:0];
        rd_issue         = 1'b0;

        // Drop the result once taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = s_tuser;
                    addr_next  = s_tdata[ADDR_W-1:0];
                    rssi_next  = s_tdata[ADDR_W+RSSI_W-1:ADDR_W];
                    tval_next  = s_tdata[IN_DATA_W-1:ADDR_W+RSSI_W];
                    acc_next   = 1'b0;
                    pres_next  = PRES_NOT_TRACKING;
                    near_next  = 1'b0;
                    found_next = 1'b0;
                    ptr_next   = '0;
                    state_next = ST_DONE;
                    case (s_tuser)
                        MODE_SCAN, MODE_REMOVE, MODE_TICK:
                        begin
                            if (used_reg != '0)
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        MODE_ADD:
                        begin
                            if (used_reg != '0)
                            begin
                                state_next = ST_WALK;
                            end
                            else
                            begin
                                // Empty table: append at entry zero
                                mem_we      = 1'b1;
                                mem_wa      = '0;
                                mem_wd.addr = s_tdata[ADDR_W-1:0];
                                mem_wd.thr  = s_tdata[ADDR_W+RSSI_W-1:ADDR_W];
                                mem_wd.cnt  = CNT_INIT;
                                used_next   = CNT_W'(1);
                                acc_next    = 1'b1;
                            end
                        end
                        MODE_SETTO:
                        begin
                            if (s_tdata[IN_DATA_W-1:ADDR_W+RSSI_W] <= CNT_INIT)
                            begin
                                if (used_reg != '0)
                                begin
                                    state_next = ST_WALK;
                                end
                                else
                                begin
                                    timeout_next = s_tdata[IN_DATA_W-1:ADDR_W+RSSI_W];
                                    acc_next     = 1'b1;
                                end
                            end
                        end
                        MODE_CLEAR:
                        begin
                            used_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                // Issue the next read
                if (ptr_reg < used_reg)
                begin
                    rd_issue    = 1'b1;
                    ptr_next    = ptr_reg + 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = ptr_reg;
                end

                // Act on the entry just read: write it back, shift it down or append after it
                if (rd_vld_reg)
                begin
                    case (mode_reg)
                        MODE_SCAN:
                        begin
                            if (match)
                            begin
                                acc_next = 1'b1;
                                if ($signed(rssi_reg) >= $signed(rd_data_reg.thr))
                                begin
                                    mem_we     = 1'b1;
                                    mem_wd.cnt = '0;
                                end
                                state_next = ST_DONE;
                            end
                            else if (last)
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        MODE_ADD:
                        begin
                            if (match)
                            begin
                                mem_we     = 1'b1;
                                mem_wd.thr = rssi_reg;
                                acc_next   = 1'b1;
                                state_next = ST_DONE;
                            end
                            else if (last)
                            begin
                                if (used_reg < CNT_W'(MAX_DEVICES))
                                begin
                                    mem_we      = 1'b1;
                                    mem_wa      = used_reg[IDX_W-1:0];
                                    mem_wd.addr = addr_reg;
                                    mem_wd.thr  = rssi_reg;
                                    mem_wd.cnt  = CNT_INIT;
                                    used_next   = used_reg + 1'b1;
                                    acc_next    = 1'b1;
                                end
                                state_next = ST_DONE;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            // Shift every entry past the hole down by one
                            if (found_reg)
                            begin
                                mem_we = 1'b1;
                                mem_wa = hole_idx[IDX_W-1:0];
                            end
                            else if (match)
                            begin
                                found_next = 1'b1;
                            end
                            if (last)
                            begin
                                if (found_reg || match)
                                begin
                                    used_next = used_reg - 1'b1;
                                    acc_next  = 1'b1;
                                end
                                state_next = ST_DONE;
                            end
                        end
                        MODE_TICK:
                        begin
                            if (rd_data_reg.cnt < timeout_reg)
                            begin
                                mem_we     = 1'b1;
                                mem_wd.cnt = rd_data_reg.cnt + 1'b1;
                                near_next  = 1'b1;
                            end
                            if (last)
                            begin
                                if (near_reg || (rd_data_reg.cnt < timeout_reg))
                                begin
                                    pres_next = PRES_SOME_NEAR;
                                end
                                else
                                begin
                                    pres_next = PRES_NONE_NEAR;
                                end
                                state_next = ST_DONE;
                            end
                        end
                        MODE_SETTO:
                        begin
                            if (rd_data_reg.cnt >= timeout_reg)
                            begin
                                mem_we     = 1'b1;
                                mem_wd.cnt = tval_reg;
                            end
                            if (last)
                            begin
                                timeout_next = tval_reg;
                                acc_next     = 1'b1;
                                state_next   = ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end

                // Discard any read still in flight
                if (state_next == ST_DONE)
                begin
                    rd_vld_next = 1'b0;
                end
            end

            ST_DONE:
            begin
                // Load the result once the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next    = 1'b1;
                    out_acc_next     = acc_reg;
                    out_pres_next    = pres_reg;
                    out_count_next   = COUNT_W'(used_reg);
                    out_timeout_next = timeout_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            timeout_reg  <= TICK_W'(DEFAULT_TIMEOUT);
            m_tvalid_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            timeout_reg  <= timeout_next;
            m_tvalid_reg <= m_tvalid_next;
            rd_vld_reg   <= rd_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        addr_reg        <= addr_next;
        rssi_reg        <= rssi_next;
        tval_reg        <= tval_next;
        ptr_reg         <= ptr_next;
        rd_idx_reg      <= rd_idx_next;
        found_reg       <= found_next;
        near_reg        <= near_next;
        acc_reg         <= acc_next;
        pres_reg        <= pres_next;
        out_acc_reg     <= out_acc_next;
        out_pres_reg    <= out_pres_next;
        out_count_reg   <= out_count_next;
        out_timeout_reg <= out_timeout_next;
    end

    // Table memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= entry_mem[mem_ra];
    end

    // Checks
    `PPT_ASSERT_NOW(a_used_bound, 1'b1, used_reg <= CNT_W'(MAX_DEVICES), "entry count above table size")
    `PPT_ASSERT_NOW(a_no_rw_clash, mem_we && rd_issue, mem_wa != mem_ra, "write hits entry being read")
    `PPT_ASSERT_NOW(a_write_when_busy, mem_we, (state_reg == ST_WALK) || accept, "table write outside an item")
    `PPT_ASSERT_NEXT(a_used_step, state_reg == ST_WALK, (used_reg == $past(used_reg)) || (used_reg == $past(used_reg) + 1'b1) || (used_reg == $past(used_reg) - 1'b1), "entry count jumped during walk")

endmodule

`default_nettype wire
